### rtl/ara_pkg.sv
// Shared widths, constants and default parameters of the ratiometric averager.
`timescale 1ns / 1ps

package ara_pkg;

    // Default parameter values.
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_HALVE_AT    = 254;
    localparam int DEF_FRAC_BITS   = 8;

    // Fixed state and field widths.
    localparam int RAW_SUM_W   = 28;
    localparam int RATIO_SUM_W = 29;
    localparam int AVG_W       = 20;
    localparam int RATIO_AVG_W = 21;
    localparam int LATEST_W    = 12;
    localparam int MV_W        = 16;

    // Supply compensation: nominal rail and the lowest reading that is trusted.
    localparam int              NOM_W         = 13;
    localparam logic [NOM_W-1:0] SUPPLY_NOM_MV = 13'd5000;
    localparam logic [MV_W-1:0]  SUPPLY_MIN_MV = 16'd3000;

    // Request codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

endpackage

### rtl/ara_divider.sv
// Restoring divider that retires one quotient bit per cycle.
`timescale 1ns / 1ps

module ara_divider #(
    parameter int DND_W = 33,
    parameter int DSR_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DND_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DND_W-1:0] quotient
);

    localparam int CW = $clog2(DND_W + 1);

    logic [DND_W-1:0] quo_reg;
    logic [DSR_W-1:0] rem_reg;
    logic [DSR_W-1:0] dsr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DSR_W:0]   shifted;
    logic [DSR_W:0]   diff;
    logic             ge;

    // One trial subtraction of the divisor from the shifted partial remainder.
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DND_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        ge      = (shifted >= {1'b0, dsr_reg});
    end

    // Control: bit counter, busy flag and the completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CW'(DND_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DND_W-2:0], ge};
            rem_reg <= ge ? diff[DSR_W-1:0] : shifted[DSR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/adc_ratiometric_averager.sv
// Top level of the ADC ratiometric averager.
// Sample transaction: with the supply below 3000 mV the sample is added uncompensated, otherwise
// a 13-step shift-add multiply by 5000 is followed by a divide that retires one bit a cycle.
// Read transaction: with no samples the stored averages are returned, otherwise two divides run.
// DND_W is the wider of the compensated product and the ratiometric sum (33 by default).
// One transaction is in flight at a time; the result register frees the input side.
// Asynchronous active-low reset clears the sums, the count and the stored averages.
`timescale 1ns / 1ps

module adc_ratiometric_averager #(
    parameter int SAMPLE_BITS = ara_pkg::DEF_SAMPLE_BITS,
    parameter int HALVE_AT    = ara_pkg::DEF_HALVE_AT,
    parameter int FRAC_BITS   = ara_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                req_type,
    input  logic [SAMPLE_BITS-1:0]              sample,
    input  logic [ara_pkg::MV_W-1:0]            supply_mv,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ara_pkg::AVG_W-1:0]           average,
    output logic [ara_pkg::RATIO_AVG_W-1:0]     ratiometric_average,
    output logic [ara_pkg::LATEST_W-1:0]        latest,
    output logic                                fresh
);

    import ara_pkg::*;

    localparam int Q_W    = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_W = Q_W + NOM_W;
    localparam int DND_W  = (PROD_W > RATIO_SUM_W) ? PROD_W : RATIO_SUM_W;
    localparam int CNT_W  = $clog2(HALVE_AT + 1);
    localparam int DSR_W  = (MV_W > CNT_W) ? MV_W : CNT_W;
    localparam int IDX_W  = $clog2(NOM_W);
    localparam logic [CNT_W-1:0] HALVE_CNT = CNT_W'(HALVE_AT);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_DTERM  = 3'd2;
    localparam logic [2:0] S_APPLY  = 3'd3;
    localparam logic [2:0] S_DRAW   = 3'd4;
    localparam logic [2:0] S_DRATIO = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0]             state_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic [MV_W-1:0]        mv_reg;
    logic                   lowsup_reg;
    logic [PROD_W-1:0]      acc_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic                   div_start_reg;

    logic [RAW_SUM_W-1:0]   raw_sum_reg;
    logic [RATIO_SUM_W-1:0] ratio_sum_reg;
    logic [CNT_W-1:0]       sample_count_reg;
    logic [AVG_W-1:0]       avg_store_reg;
    logic [RATIO_AVG_W-1:0] ratio_avg_store_reg;
    logic [LATEST_W-1:0]    latest_store_reg;
    logic                   fresh_flag_reg;

    logic                   out_valid_reg;
    logic [AVG_W-1:0]       average_reg;
    logic [RATIO_AVG_W-1:0] ratio_average_reg;
    logic [LATEST_W-1:0]    latest_reg;
    logic                   fresh_reg;

    logic [Q_W-1:0]         q_val;
    logic [PROD_W-1:0]      mul_addend;
    logic [RATIO_SUM_W-1:0] term;
    logic [RAW_SUM_W-1:0]   raw_sum_next;
    logic [RATIO_SUM_W-1:0] ratio_sum_next;
    logic [CNT_W-1:0]       count_next;
    logic                   halve;
    logic [DND_W-1:0]       div_dividend;
    logic [DSR_W-1:0]       div_divisor;
    logic                   div_done;
    logic [DND_W-1:0]       div_quotient;

    // Sample in fixed point, multiplier addend and the accumulated sums.
    always_comb
    begin
        q_val          = Q_W'(smp_reg) << FRAC_BITS;
        mul_addend     = SUPPLY_NOM_MV[idx_reg] ? PROD_W'(q_val) : '0;
        term           = lowsup_reg ? RATIO_SUM_W'(q_val) : div_quotient[RATIO_SUM_W-1:0];
        raw_sum_next   = raw_sum_reg + RAW_SUM_W'(q_val);
        ratio_sum_next = ratio_sum_reg + term;
        count_next     = sample_count_reg + CNT_W'(1);
        halve          = (count_next >= HALVE_CNT);
    end

    // Divider operands follow the division that the sequencer is running.
    always_comb
    begin
        unique case (state_reg)
            S_DRAW:
            begin
                div_dividend = DND_W'(raw_sum_reg);
                div_divisor  = DSR_W'(sample_count_reg);
            end
            S_DRATIO:
            begin
                div_dividend = DND_W'(ratio_sum_reg);
                div_divisor  = DSR_W'(sample_count_reg);
            end
            default:
            begin
                div_dividend = DND_W'(acc_reg);
                div_divisor  = DSR_W'(mv_reg);
            end
        endcase
    end

    ara_divider #(
        .DND_W (DND_W),
        .DSR_W (DSR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            div_start_reg       <= 1'b0;
            raw_sum_reg         <= '0;
            ratio_sum_reg       <= '0;
            sample_count_reg    <= '0;
            avg_store_reg       <= '0;
            ratio_avg_store_reg <= '0;
            latest_store_reg    <= '0;
            fresh_flag_reg      <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (req_type == REQ_SAMPLE)
                        begin
                            latest_store_reg <= LATEST_W'(sample);
                            fresh_flag_reg   <= 1'b0;
                            if (supply_mv < SUPPLY_MIN_MV)
                            begin
                                state_reg <= S_APPLY;
                            end
                            else
                            begin
                                state_reg <= S_MUL;
                            end
                        end
                        else if (sample_count_reg == '0)
                        begin
                            fresh_flag_reg <= 1'b0;
                            state_reg      <= S_FINISH;
                        end
                        else
                        begin
                            div_start_reg <= 1'b1;
                            state_reg     <= S_DRAW;
                        end
                    end
                end
                S_MUL:
                begin
                    if (idx_reg == '0)
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DTERM;
                    end
                end
                S_DTERM:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_APPLY;
                    end
                end
                S_APPLY:
                begin
                    // Add the sample and halve everything once the count is full.
                    if (halve)
                    begin
                        raw_sum_reg      <= raw_sum_next >> 1;
                        ratio_sum_reg    <= ratio_sum_next >> 1;
                        sample_count_reg <= count_next >> 1;
                    end
                    else
                    begin
                        raw_sum_reg      <= raw_sum_next;
                        ratio_sum_reg    <= ratio_sum_next;
                        sample_count_reg <= count_next;
                    end
                    state_reg <= S_FINISH;
                end
                S_DRAW:
                begin
                    if (div_done)
                    begin
                        avg_store_reg <= div_quotient[AVG_W-1:0];
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DRATIO;
                    end
                end
                S_DRATIO:
                begin
                    if (div_done)
                    begin
                        ratio_avg_store_reg <= div_quotient[RATIO_AVG_W-1:0];
                        raw_sum_reg         <= '0;
                        ratio_sum_reg       <= '0;
                        sample_count_reg    <= '0;
                        fresh_flag_reg      <= 1'b1;
                        state_reg           <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Operand capture and the shift-add multiply by the nominal supply.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            smp_reg    <= sample;
            mv_reg     <= supply_mv;
            lowsup_reg <= (supply_mv < SUPPLY_MIN_MV);
            acc_reg    <= '0;
            idx_reg    <= IDX_W'(NOM_W - 1);
        end
        else if (state_reg == S_MUL)
        begin
            acc_reg <= (acc_reg << 1) + mul_addend;
            idx_reg <= idx_reg - IDX_W'(1);
        end
    end

    // Result register, loaded when the transaction completes.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && (!out_valid_reg || out_ready))
        begin
            average_reg       <= avg_store_reg;
            ratio_average_reg <= ratio_avg_store_reg;
            latest_reg        <= latest_store_reg;
            fresh_reg         <= fresh_flag_reg;
        end
    end

    assign in_ready            = (state_reg == S_IDLE);
    assign out_valid           = out_valid_reg;
    assign average             = average_reg;
    assign ratiometric_average = ratio_average_reg;
    assign latest              = latest_reg;
    assign fresh               = fresh_reg;

endmodule

### bench/adc_ratiometric_averager_tb.sv
// Self-checking testbench for the ADC ratiometric averager: directed table, then random bursts.
`timescale 1ns / 1ps

module adc_ratiometric_averager_tb;

    import ara_pkg::*;

    localparam int SMP_W           = DEF_SAMPLE_BITS;
    localparam int RANDOM_ITEMS    = 1830;
    localparam int HOLD_OFF_CYCLES = 500;
    localparam int TAIL_CYCLES     = 200;
    localparam int RUN_LIMIT       = 1000000;
    localparam int REPORT_LIMIT    = 10;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [AVG_W-1:0]       avg;
        logic [RATIO_AVG_W-1:0] ratio_avg;
        logic [LATEST_W-1:0]    latest;
        logic                   fresh;
    } reading_t;

    // One row of the directed table; known rows carry a typed-in result.
    typedef struct packed {
        logic             rq;
        logic [SMP_W-1:0] smp;
        logic [MV_W-1:0]  mv;
        logic             known;
        reading_t         want;
    } step_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic                   req_type;
    logic [SMP_W-1:0]       sample;
    logic [MV_W-1:0]        supply_mv;
    logic                   out_valid;
    logic                   out_ready;
    logic [AVG_W-1:0]       average;
    logic [RATIO_AVG_W-1:0] ratiometric_average;
    logic [LATEST_W-1:0]    latest;
    logic                   fresh;

    // Predicted state of the averager.
    logic [RAW_SUM_W-1:0]   acc_raw;
    logic [RATIO_SUM_W-1:0] acc_ratio;
    logic [7:0]             acc_count;
    logic [AVG_W-1:0]       held_avg;
    logic [RATIO_AVG_W-1:0] held_ratio_avg;
    logic [LATEST_W-1:0]    held_latest;

    reading_t pending_readings[$];
    step_t    directed_plan[$];

    int cycle_count   = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int n_samples     = 0;
    int n_reads       = 0;
    int n_fresh       = 0;
    int n_low_supply  = 0;
    int n_halvings    = 0;

    adc_ratiometric_averager u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .req_type            (req_type),
        .sample              (sample),
        .supply_mv           (supply_mv),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .average             (average),
        .ratiometric_average (ratiometric_average),
        .latest              (latest),
        .fresh               (fresh)
    );

    // 50 MHz clock.
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Applies one request to the predicted state and returns the reading it produces.
    function automatic reading_t apply_request(input logic rq, input logic [SMP_W-1:0] smp,
                                               input logic [MV_W-1:0] mv);
        logic [63:0] q;
        logic [63:0] term;
        logic [63:0] wide;
        reading_t    r;
        r.fresh = 1'b0;
        if (rq == REQ_SAMPLE)
        begin
            q           = 64'(smp) << DEF_FRAC_BITS;
            held_latest = smp;
            wide        = 64'(acc_raw) + q;
            acc_raw     = wide[RAW_SUM_W-1:0];
            // A low or missing rail reading adds the sample uncompensated.
            if (mv < SUPPLY_MIN_MV)
            begin
                term = q;
                n_low_supply++;
            end
            else
                term = (q * 64'(SUPPLY_NOM_MV)) / 64'(mv);
            wide      = 64'(acc_ratio) + term;
            acc_ratio = wide[RATIO_SUM_W-1:0];
            acc_count = acc_count + 8'd1;
            if (acc_count >= DEF_HALVE_AT)
            begin
                acc_raw   = acc_raw >> 1;
                acc_ratio = acc_ratio >> 1;
                acc_count = acc_count >> 1;
                n_halvings++;
            end
        end
        else if (acc_count != 8'd0)
        begin
            wide           = 64'(acc_raw) / 64'(acc_count);
            held_avg       = wide[AVG_W-1:0];
            wide           = 64'(acc_ratio) / 64'(acc_count);
            held_ratio_avg = wide[RATIO_AVG_W-1:0];
            acc_raw        = '0;
            acc_ratio      = '0;
            acc_count      = '0;
            r.fresh        = 1'b1;
        end
        r.avg       = held_avg;
        r.ratio_avg = held_ratio_avg;
        r.latest    = held_latest;
        return r;
    endfunction

    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [SMP_W-1:0] pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else
            return SMP_W'($urandom_range(0, 4095));
    endfunction

    // Rail readings: exact thresholds, low supply, the whole range and near nominal.
    function automatic logic [MV_W-1:0] pick_mv();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return SUPPLY_MIN_MV - 16'd1;
        else if (r == 2)
            return SUPPLY_MIN_MV;
        else if (r == 3)
            return '1;
        else if (r < 8)
            return MV_W'($urandom_range(1, 2999));
        else if (r < 12)
            return MV_W'($urandom_range(0, 65535));
        else
            return MV_W'($urandom_range(4000, 6000));
    endfunction

    task automatic plan(input logic rq, input int smp, input int mv, input bit known,
                        input int avg, input int ratio_avg, input int lat, input bit fr);
        step_t s;
        s.rq             = rq;
        s.smp            = SMP_W'(smp);
        s.mv             = MV_W'(mv);
        s.known          = known;
        s.want.avg       = AVG_W'(avg);
        s.want.ratio_avg = RATIO_AVG_W'(ratio_avg);
        s.want.latest    = LATEST_W'(lat);
        s.want.fresh     = fr;
        directed_plan.push_back(s);
    endtask

    // Offers one request, records its expected reading on acceptance, then idles for the gap, if any.
    task automatic issue(input logic rq, input logic [SMP_W-1:0] smp, input logic [MV_W-1:0] mv,
                         input bit known, input reading_t want, input int gap);
        reading_t predicted;
        in_valid  <= 1'b1;
        req_type  <= rq;
        sample    <= smp;
        supply_mv <= mv;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_request(rq, smp, mv);
        pending_readings.push_back(known ? want : predicted);
        if (rq == REQ_SAMPLE)
            n_samples++;
        else
        begin
            n_reads++;
            if (predicted.fresh)
                n_fresh++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_readings.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Result checker: every accepted transaction is compared with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        reading_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_readings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Unexpected result: avg=%0d ratio=%0d latest=%0d fresh=%0b",
                             average, ratiometric_average, latest, fresh);
            end
            else
            begin
                want = pending_readings.pop_front();
                if (average !== want.avg || ratiometric_average !== want.ratio_avg ||
                    latest !== want.latest || fresh !== want.fresh)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("Result %0d: expected avg=%0d ratio=%0d latest=%0d fresh=%0b",
                                 results_seen, want.avg, want.ratio_avg, want.latest,
                                 want.fresh);
                        $display("    got avg=%0d ratio=%0d latest=%0d fresh=%0b",
                                 average, ratiometric_average, latest, fresh);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, and one long hold-off so that the block backs up.
    initial
    begin : receiver
        int  stretch;
        int  stall;
        bit  held_off;
        out_ready = 1'b0;
        held_off  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stretch = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                   : $urandom_range(40, 200);
            out_ready <= 1'b1;
            repeat (stretch) @(posedge clk);
            if (!held_off && results_seen >= 150)
            begin
                held_off = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = pick_gap(1'b0);
                if (stall > 0)
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        reading_t none;
        int       burst;
        int       run_len;
        int       n_random;
        bit       quiet;
        int       mode;

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        req_type  = REQ_SAMPLE;
        sample    = '0;
        supply_mv = '0;
        acc_raw        = '0;
        acc_ratio      = '0;
        acc_count      = '0;
        held_avg       = '0;
        held_ratio_avg = '0;
        held_latest    = '0;
        none           = '0;

        // Read straight after reset, full-scale samples, empty reads and rail thresholds.
        plan(REQ_READ,   0,    0,     1, 0,       0,       0,    0);
        plan(REQ_SAMPLE, 4095, 5000,  1, 0,       0,       4095, 0);
        plan(REQ_READ,   0,    0,     1, 1048320, 1048320, 4095, 1);
        plan(REQ_READ,   0,    0,     1, 1048320, 1048320, 4095, 0);
        plan(REQ_SAMPLE, 4095, 3000,  1, 1048320, 1048320, 4095, 0);
        plan(REQ_READ,   0,    0,     1, 1048320, 1747200, 4095, 1);
        plan(REQ_SAMPLE, 0,    0,     1, 1048320, 1747200, 0,    0);
        plan(REQ_READ,   0,    0,     1, 0,       0,       0,    1);
        plan(REQ_SAMPLE, 4095, 2999,  1, 0,       0,       4095, 0);
        plan(REQ_READ,   0,    0,     1, 1048320, 1048320, 4095, 1);
        // Mixed rails, including the largest reading and a reading of one.
        plan(REQ_SAMPLE, 4095, 65535, 0, 0, 0, 0, 0);
        plan(REQ_SAMPLE, 1,    65535, 0, 0, 0, 0, 0);
        plan(REQ_SAMPLE, 2048, 3001,  0, 0, 0, 0, 0);
        plan(REQ_SAMPLE, 100,  1,     0, 0, 0, 0, 0);
        plan(REQ_READ,   4095, 65535, 0, 0, 0, 0, 0);
        plan(REQ_SAMPLE, 2730, 4999,  0, 0, 0, 0, 0);
        plan(REQ_SAMPLE, 1365, 5001,  0, 0, 0, 0, 0);
        plan(REQ_SAMPLE, 4094, 32768, 0, 0, 0, 0, 0);
        plan(REQ_READ,   0,    0,     0, 0, 0, 0, 0);
        plan(REQ_READ,   0,    0,     0, 0, 0, 0, 0);
        plan(REQ_SAMPLE, 0,    65535, 0, 0, 0, 0, 0);
        plan(REQ_READ,   0,    0,     0, 0, 0, 0, 0);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_plan[i])
            issue(directed_plan[i].rq, directed_plan[i].smp, directed_plan[i].mv,
                  directed_plan[i].known, directed_plan[i].want, pick_gap(1'b0));

        // Random bursts: short and long sample runs closed by a read, plus noise.
        burst    = 0;
        n_random = 0;
        while (n_random < RANDOM_ITEMS)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            mode  = (burst == 0) ? 0 : $urandom_range(0, 99);
            if (mode < 8)
            begin
                // Long enough that the sums and the count can be halved.
                run_len = $urandom_range(250, 300);
                repeat (run_len)
                    issue(REQ_SAMPLE, pick_sample(), pick_mv(), 1'b0, none, pick_gap(quiet));
                issue(REQ_READ, pick_sample(), pick_mv(), 1'b0, none, pick_gap(quiet));
                n_random += run_len + 1;
            end
            else if (mode < 85)
            begin
                run_len = $urandom_range(1, 30);
                repeat (run_len)
                    issue(REQ_SAMPLE, pick_sample(), pick_mv(), 1'b0, none, pick_gap(quiet));
                issue(REQ_READ, pick_sample(), pick_mv(), 1'b0, none, pick_gap(quiet));
                n_random += run_len + 1;
            end
            else
            begin
                // Noise: random request types, so empty and back-to-back reads occur.
                run_len = $urandom_range(1, 10);
                repeat (run_len)
                    issue(($urandom_range(0, 1) == 1) ? REQ_READ : REQ_SAMPLE, pick_sample(),
                          pick_mv(), 1'b0, none, pick_gap(quiet));
                n_random += run_len;
            end
            burst++;
        end
        in_valid <= 1'b0;

        // Drain, then watch for stray results.
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d samples (%0d on a low rail) and %0d reads (%0d fresh).",
                 n_samples, n_low_supply, n_reads, n_fresh);
        $display("Sums were halved %0d times; %0d results checked, %0d mismatches.",
                 n_halvings, results_seen, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
rtl/ara_pkg.sv
rtl/ara_divider.sv
rtl/adc_ratiometric_averager.sv
bench/adc_ratiometric_averager_tb.sv
